>>> sv/hci_pkg.sv
// ----------------------------------------------------------------------------
// hci_pkg
// Shared types, constants and a helper function for the HSV color interpolator.
// ----------------------------------------------------------------------------
package hci_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned BLEND_W = 17;
  localparam int unsigned HNUM_W  = 17;

  // hue sector, red through magenta
  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  typedef struct packed {
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   dlt;
    logic [HNUM_W-1:0] hnum;
  } prep_t;

  // max, spread and hue numerator in degrees times spread
  function automatic prep_t color_prep(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                       logic [CH_W-1:0] b);
    prep_t             p;
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mn;
    logic [HNUM_W-1:0] dd;
    logic [HNUM_W-1:0] res;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dd = HNUM_W'(mx - mn);
    if (mx == r) begin
      if (g >= b) res = HNUM_W'(60) * HNUM_W'(g - b);
      else        res = HNUM_W'(360) * dd - HNUM_W'(60) * HNUM_W'(b - g);
    end else if (mx == g) begin
      if (b >= r) res = HNUM_W'(120) * dd + HNUM_W'(60) * HNUM_W'(b - r);
      else        res = HNUM_W'(120) * dd - HNUM_W'(60) * HNUM_W'(r - b);
    end else begin
      if (r >= g) res = HNUM_W'(240) * dd + HNUM_W'(60) * HNUM_W'(r - g);
      else        res = HNUM_W'(240) * dd - HNUM_W'(60) * HNUM_W'(g - r);
    end
    p.mx   = mx;
    p.dlt  = mx - mn;
    p.hnum = res;
    return p;
  endfunction

endpackage

>>> sv/hsv_color_interpolator.sv
// ----------------------------------------------------------------------------
// hsv_color_interpolator
// Blends two RGB colors through HSV space, one color pair per clock unless the receiver stalls.
// ----------------------------------------------------------------------------
// Input channel: start and end colors plus blend_fraction, a transfer on
// in_valid_i and in_ready_o. Output channel: the blended RGB color, a
// transfer on out_valid_o and out_ready_i.
// Throughput is one transfer per clock. The delay through the pipeline is set
// by the bit-per-stage divider bank that forms hue and saturation, with
// quotient width QW = max(VW, HUE_FRACTION_BITS + 9), VW = FRACTION_BITS + 1;
// value is taken alongside by a reciprocal multiply. The sector remainder is
// scaled by a shift and one reciprocal multiply stage.
// When the receiver stalls the whole pipeline holds and in_ready_o drops;
// nothing is lost or repeated. Reset clears all valid bits, the pipeline comes
// up empty and ready.
// ----------------------------------------------------------------------------
module hsv_color_interpolator
  import hci_pkg::*;
#(
  parameter int unsigned FRACTION_BITS     = 16,
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [CH_W-1:0]    start_red_i,
  input  logic [CH_W-1:0]    start_green_i,
  input  logic [CH_W-1:0]    start_blue_i,
  input  logic [CH_W-1:0]    end_red_i,
  input  logic [CH_W-1:0]    end_green_i,
  input  logic [CH_W-1:0]    end_blue_i,
  input  logic [BLEND_W-1:0] blend_fraction_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [CH_W-1:0]    out_red_o,
  output logic [CH_W-1:0]    out_green_o,
  output logic [CH_W-1:0]    out_blue_o
);

  localparam int unsigned F   = FRACTION_BITS;
  localparam int unsigned HF  = HUE_FRACTION_BITS;
  localparam int unsigned VW  = F + 1;
  localparam int unsigned HW  = HF + 9;
  localparam int unsigned QW  = (VW > HW) ? VW : HW;
  localparam int unsigned NW  = CH_W + QW;
  localparam int unsigned RW  = HF + 6;
  localparam int unsigned XW  = RW + VW;
  localparam int unsigned PHW = HW + VW;
  localparam int unsigned PVW = 2 * VW;
  localparam int unsigned OW  = VW + CH_W;
  localparam int unsigned TW  = (VW > BLEND_W) ? VW : BLEND_W;
  localparam int unsigned VNW = CH_W + F;
  localparam int unsigned VMW = VW + 8;
  localparam int unsigned VKW = F + 16;
  localparam int unsigned VPW = VNW + VMW;
  localparam int unsigned QSW = XW - HF - 2;
  localparam int unsigned KR  = F + 8;
  localparam int unsigned XPW = 2 * QSW;

  localparam logic [VW-1:0]  ONE   = VW'(1) << F;
  localparam logic [RW-1:0]  DEG60 = RW'(60) << HF;
  localparam logic [HW-1:0]  B1    = HW'(60) << HF;
  localparam logic [HW-1:0]  B2    = HW'(120) << HF;
  localparam logic [HW-1:0]  B3    = HW'(180) << HF;
  localparam logic [HW-1:0]  B4    = HW'(240) << HF;
  localparam logic [HW-1:0]  B5    = HW'(300) << HF;
  localparam logic [VMW-1:0] VRCP  = VMW'(((64'd1 << VKW) + 64'd254) / 64'd255);
  localparam logic [QSW-1:0] RCP15 = QSW'(((64'd1 << KR) + 64'd14) / 64'd15);

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage 1: per color max, spread, hue numerator; clamped blend fraction
  logic          v1_q;
  prep_t         p1_q [2];
  logic [VW-1:0] t1_q;
  logic [VW-1:0] t1_d;

  always_comb begin
    if (TW'(blend_fraction_i) > TW'(ONE)) t1_d = ONE;
    else                                 t1_d = VW'(blend_fraction_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q[0] <= color_prep(start_red_i, start_green_i, start_blue_i);
      p1_q[1] <= color_prep(end_red_i, end_green_i, end_blue_i);
      t1_q    <= t1_d;
    end
  end

  // divider bank: hue, saturation; value by reciprocal of 255
  logic [QW-1:0] hq [2];
  logic [QW-1:0] sq [2];
  logic [QW-1:0] vq [2];

  for (genvar k = 0; k < 2; k++) begin : g_col
    logic [NW-1:0]   h_num;
    logic [CH_W-1:0] h_den;
    logic [NW-1:0]   s_num;
    logic [CH_W-1:0] s_den;
    logic [VNW-1:0]  v_num;
    logic [VPW-1:0]  v_prod;
    logic [QW-1:0]   v_val;
    logic [QW-1:0]   vl_q [QW];

    assign h_num = NW'(p1_q[k].hnum) << HF;
    assign h_den = (p1_q[k].dlt == '0) ? CH_W'(1) : p1_q[k].dlt;
    assign s_num = (p1_q[k].dlt == '0) ? '0
                 : (NW'(p1_q[k].dlt) << F) + NW'(p1_q[k].mx) - NW'(1);
    assign s_den = (p1_q[k].mx == '0) ? CH_W'(1) : p1_q[k].mx;
    assign v_num  = (VNW'(p1_q[k].mx) << F) + VNW'(254);
    assign v_prod = VPW'(v_num) * VPW'(VRCP);
    assign v_val  = QW'(v_prod[VKW +: VW]);

    hci_div #(.DW(CH_W), .QW(QW)) u_hdiv (
      .clk_i, .en_i(adv), .num_i(h_num), .den_i(h_den), .quo_o(hq[k])
    );
    hci_div #(.DW(CH_W), .QW(QW)) u_sdiv (
      .clk_i, .en_i(adv), .num_i(s_num), .den_i(s_den), .quo_o(sq[k])
    );

    always_ff @(posedge clk_i) begin
      if (adv) begin
        vl_q[0] <= v_val;
        for (int i = 1; i < QW; i++) vl_q[i] <= vl_q[i-1];
      end
    end

    assign vq[k] = vl_q[QW-1];
  end

  logic [QW-1:0] vd_q;
  logic [VW-1:0] td_q [QW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      td_q[0] <= t1_q;
      for (int i = 1; i < QW; i++) td_q[i] <= td_q[i-1];
    end
  end

  // stage 2: blend products
  logic           v2_q;
  logic [PHW-1:0] ph_q [2];
  logic [PVW-1:0] ps_q [2];
  logic [PVW-1:0] pv_q [2];
  logic [VW-1:0]  tb;
  logic [VW-1:0]  omt;

  assign tb  = td_q[QW-1];
  assign omt = ONE - tb;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q[0] <= PHW'(hq[0][HW-1:0]) * PHW'(omt);
      ph_q[1] <= PHW'(hq[1][HW-1:0]) * PHW'(tb);
      ps_q[0] <= PVW'(sq[0][VW-1:0]) * PVW'(omt);
      ps_q[1] <= PVW'(sq[1][VW-1:0]) * PVW'(tb);
      pv_q[0] <= PVW'(vq[0][VW-1:0]) * PVW'(omt);
      pv_q[1] <= PVW'(vq[1][VW-1:0]) * PVW'(tb);
    end
  end

  // stage 3: blend sums
  logic          v3_q;
  logic [HW-1:0] h3_q;
  logic [VW-1:0] s3_q;
  logic [VW-1:0] v3v_q;
  logic [PHW:0]  hsum;
  logic [PVW:0]  ssum;
  logic [PVW:0]  vsum;

  assign hsum = {1'b0, ph_q[0]} + {1'b0, ph_q[1]};
  assign ssum = {1'b0, ps_q[0]} + {1'b0, ps_q[1]};
  assign vsum = {1'b0, pv_q[0]} + {1'b0, pv_q[1]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h3_q  <= hsum[F +: HW];
      s3_q  <= ssum[F +: VW];
      v3v_q <= vsum[F +: VW];
    end
  end

  // stage 4: chroma product
  logic           v4_q;
  logic [HW-1:0]  h4_q;
  logic [VW-1:0]  v4v_q;
  logic [PVW-1:0] vs4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h4_q  <= h3_q;
      v4v_q <= v3v_q;
      vs4_q <= PVW'(v3v_q) * PVW'(s3_q);
    end
  end

  // stage 5: chroma, offset, sector and remainder operand
  logic          v5_q;
  logic [VW-1:0] c5_q;
  logic [VW-1:0] m5_q;
  sector_e       sec5_q;
  logic [RW-1:0] op5_q;
  logic [VW-1:0] c5_raw;
  logic [VW-1:0] c5_d;
  logic [2:0]    scnt;
  sector_e       sec5_d;
  logic [HW-1:0] base;
  logic [RW-1:0] rem5;
  logic [RW-1:0] op5_d;

  assign c5_raw = vs4_q[F +: VW];
  assign c5_d   = (c5_raw > v4v_q) ? v4v_q : c5_raw;
  assign scnt   = 3'(h4_q >= B1) + 3'(h4_q >= B2) + 3'(h4_q >= B3)
                + 3'(h4_q >= B4) + 3'(h4_q >= B5);

  always_comb begin
    case (scnt)
      3'd0:    begin sec5_d = SEC_RY; base = '0; end
      3'd1:    begin sec5_d = SEC_YG; base = B1; end
      3'd2:    begin sec5_d = SEC_GC; base = B2; end
      3'd3:    begin sec5_d = SEC_CB; base = B3; end
      3'd4:    begin sec5_d = SEC_BM; base = B4; end
      default: begin sec5_d = SEC_MR; base = B5; end
    endcase
  end

  assign rem5  = RW'(h4_q - base);
  assign op5_d = (sec5_d == SEC_YG || sec5_d == SEC_CB || sec5_d == SEC_MR)
               ? DEG60 - rem5 : rem5;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c5_q   <= c5_d;
      m5_q   <= v4v_q - c5_d;
      sec5_q <= sec5_d;
      op5_q  <= op5_d;
    end
  end

  // stage 6: secondary component product
  logic          v6_q;
  logic [XW-1:0] pr6_q;
  logic [VW-1:0] c6_q;
  logic [VW-1:0] m6_q;
  sector_e       sec6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr6_q  <= XW'(c5_q) * XW'(op5_q);
      c6_q   <= c5_q;
      m6_q   <= m5_q;
      sec6_q <= sec5_q;
    end
  end

  // stage 7: divide by one sector width, a shift then a reciprocal of 15
  logic           v7_q;
  logic [XPW-1:0] pr7_q;
  logic [VW-1:0]  c7_q;
  logic [VW-1:0]  m7_q;
  sector_e        sec7_q;
  logic [VW-1:0]  xq;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr7_q  <= XPW'(pr6_q[XW-1:HF+2]) * XPW'(RCP15);
      c7_q   <= c6_q;
      m7_q   <= m6_q;
      sec7_q <= sec6_q;
    end
  end

  assign xq = pr7_q[KR +: VW];

  // stage 8: sector mapping and channel scaling
  logic [VW-1:0] cf;
  logic [VW-1:0] mf;
  logic [VW-1:0] rc;
  logic [VW-1:0] gc;
  logic [VW-1:0] bc;
  logic [OW-1:0] ry;
  logic [OW-1:0] gy;
  logic [OW-1:0] by;
  logic [OW-1:0] rs;
  logic [OW-1:0] gs;
  logic [OW-1:0] bs;
  logic          out_valid_q;

  assign cf = c7_q;
  assign mf = m7_q;

  always_comb begin
    case (sec7_q)
      SEC_RY:  begin rc = cf; gc = xq; bc = '0; end
      SEC_YG:  begin rc = xq; gc = cf; bc = '0; end
      SEC_GC:  begin rc = '0; gc = cf; bc = xq; end
      SEC_CB:  begin rc = '0; gc = xq; bc = cf; end
      SEC_BM:  begin rc = xq; gc = '0; bc = cf; end
      default: begin rc = cf; gc = '0; bc = xq; end
    endcase
  end

  assign ry = OW'(rc) + OW'(mf);
  assign gy = OW'(gc) + OW'(mf);
  assign by = OW'(bc) + OW'(mf);
  assign rs = (ry << CH_W) - ry;
  assign gs = (gy << CH_W) - gy;
  assign bs = (by << CH_W) - by;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_red_o   <= rs[F +: CH_W];
      out_green_o <= gs[F +: CH_W];
      out_blue_o  <= bs[F +: CH_W];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      vd_q        <= '0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= in_valid_i;
      vd_q        <= {vd_q[QW-2:0], v1_q};
      v2_q        <= vd_q[QW-1];
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      out_valid_q <= v7_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // checks
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v1_q)
    else $error("accepted transfer did not enter the pipeline");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(vd_q) && $stable(v7_q) && $stable(v3_q) && $stable(v5_q))
    else $error("valid bits moved during a stall");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> op5_q <= DEG60)
    else $error("sector remainder operand out of range");

  a_chroma_le_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v6_q |-> (VW+1)'(c6_q) + (VW+1)'(m6_q) <= (VW+1)'(ONE))
    else $error("chroma plus offset exceeds one");

endmodule

>>> sv/hci_div.sv
// ----------------------------------------------------------------------------
// hci_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module hci_div #(
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 16
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DW+QW-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QW-1:0]    quo_o
);

  localparam int unsigned NW = DW + QW;

  logic [NW-1:0] w_q  [QW];
  logic [DW-1:0] dn_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [NW-1:0] src;
    logic [DW-1:0] den;
    logic [DW:0]   part;
    logic [DW:0]   diff;
    logic [NW-1:0] w_d;

    if (i == 0) begin : g_first
      assign src = num_i;
      assign den = den_i;
    end else begin : g_next
      assign src = w_q[i-1];
      assign den = dn_q[i-1];
    end

    assign part = src[NW-1:QW-1];
    assign diff = part - {1'b0, den};

    always_comb begin
      if (!diff[DW]) w_d = {diff[DW-1:0], src[QW-2:0], 1'b1};
      else           w_d = {part[DW-1:0], src[QW-2:0], 1'b0};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[i]  <= w_d;
        dn_q[i] <= den;
      end
    end
  end

  assign quo_o = w_q[QW-1][QW-1:0];

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for hsv_color_interpolator: a directed table of color
// pairs followed by random traffic, each output transfer compared against an
// HSV blend predictor, with random idling on both sides and one long stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned FB        = 16;
  localparam int unsigned HFB       = 6;
  localparam longint      ONE       = 64'd1 << FB;
  localparam longint      DEG60     = 64'd60 << HFB;
  localparam int          N_RANDOM  = 1080;
  localparam int          LATENCY   = 25;
  localparam longint      MAX_CYCLE = 400000;

  typedef struct packed {
    logic [7:0]  sr;
    logic [7:0]  sg;
    logic [7:0]  sb;
    logic [7:0]  er;
    logic [7:0]  eg;
    logic [7:0]  eb;
    logic [16:0] frac;
  } pair_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    pair_t p;
    logic  known;
    rgb_t  c;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  start_red_i = '0, start_green_i = '0, start_blue_i = '0;
  logic [7:0]  end_red_i = '0, end_green_i = '0, end_blue_i = '0;
  logic [16:0] blend_fraction_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  out_red_o, out_green_o, out_blue_o;

  rgb_t   expected_colors[$];
  int     errors = 0;
  longint cycle = 0;
  bit     feed_done = 1'b0;
  bit     hold_req = 1'b0;
  bit     hold_off = 1'b0;

  hsv_color_interpolator dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void rgb2hsv(input longint r, g, b, output longint h, s, v);
    longint mx, mn, d, num;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    v = ((mx << FB) + 254) / 255;
    s = 0;
    h = 0;
    if (d != 0) begin
      s = ((d << FB) + mx - 1) / mx;
      if (mx == r) num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
      else if (mx == g) num = 120 * d + 60 * (b - r);
      else num = 240 * d + 60 * (r - g);
      h = (num << HFB) / d;
    end
  endfunction

  function automatic rgb_t blend_color(pair_t p);
    longint h0, s0, v0, h1, s1, v1, t, h, s, v, c, m, x, rem, sec, rc, gc, bc;
    rgb_t   o;
    rgb2hsv(p.sr, p.sg, p.sb, h0, s0, v0);
    rgb2hsv(p.er, p.eg, p.eb, h1, s1, v1);
    t = (p.frac > ONE) ? ONE : p.frac;
    h = (h0 * (ONE - t) + h1 * t) >> FB;
    s = (s0 * (ONE - t) + s1 * t) >> FB;
    v = (v0 * (ONE - t) + v1 * t) >> FB;
    c = (v * s) >> FB;
    if (c > v) c = v;
    m = v - c;
    sec = h / DEG60;
    rem = h % DEG60;
    if (sec > 5) sec = 5;
    x = (sec % 2 == 0) ? (c * rem) / DEG60 : (c * (DEG60 - rem)) / DEG60;
    case (sec)
      0: begin rc = c; gc = x; bc = 0; end
      1: begin rc = x; gc = c; bc = 0; end
      2: begin rc = 0; gc = c; bc = x; end
      3: begin rc = 0; gc = x; bc = c; end
      4: begin rc = x; gc = 0; bc = c; end
      default: begin rc = c; gc = 0; bc = x; end
    endcase
    o.r = 8'(((rc + m) * 255) >> FB);
    o.g = 8'(((gc + m) * 255) >> FB);
    o.b = 8'(((bc + m) * 255) >> FB);
    return o;
  endfunction

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_pair(pair_t p);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    start_red_i      <= p.sr;
    start_green_i    <= p.sg;
    start_blue_i     <= p.sb;
    end_red_i        <= p.er;
    end_green_i      <= p.eg;
    end_blue_i       <= p.eb;
    blend_fraction_i <= p.frac;
    do @(posedge clk_i); while (!in_ready_o);
    expected_colors.push_back(blend_color(p));
  endtask

  function automatic pair_t rand_pair();
    pair_t p;
    int    k;
    p = pair_t'({$urandom, $urandom, 1'b0});
    k = $urandom_range(0, 9);
    if (k == 0) p.frac = 17'h10000 + 17'($urandom_range(0, 65535));
    else if (k == 1) p.frac = 17'($urandom_range(0, 1) << 16);
    else p.frac = 17'($urandom_range(0, 65535));
    if ($urandom_range(0, 9) == 0) begin
      p.sg = p.sr;
      p.sb = p.sr;
    end
    if ($urandom_range(0, 9) == 0) p.eb = p.er;
    return p;
  endfunction

  row_t directed[] = '{
    '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 17'd0}, 1'b1, '{8'd255, 8'd0, 8'd0}},
    '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 17'h10000}, 1'b1, '{8'd0, 8'd0, 8'd255}},
    '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 17'h1ffff}, 1'b1, '{8'd0, 8'd255, 8'd0}},
    '{'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 17'h08000}, 1'b1, '{8'd0, 8'd0, 8'd0}},
    '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 17'd0}, 1'b1, '{8'd255, 8'd255, 8'd255}},
    '{'{8'd128, 8'd128, 8'd128, 8'd1, 8'd1, 8'd1, 17'h10001}, 1'b1, '{8'd1, 8'd1, 8'd1}},
    '{'{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 17'h08000}, 1'b0, '0},
    '{'{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 17'h08000}, 1'b0, '0},
    '{'{8'd255, 8'd0, 8'd1, 8'd255, 8'd1, 8'd0, 17'h0ffff}, 1'b0, '0},
    '{'{8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 17'h04000}, 1'b0, '0},
    '{'{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 17'h0c000}, 1'b0, '0},
    '{'{8'd10, 8'd200, 8'd250, 8'd250, 8'd100, 8'd5, 17'd1}, 1'b0, '0},
    '{'{8'd0, 8'd0, 8'd0, 8'd255, 8'd128, 8'd0, 17'h0aaaa}, 1'b0, '0},
    '{'{8'd200, 8'd100, 8'd150, 8'd120, 8'd120, 8'd120, 17'h05555}, 1'b0, '0},
    '{'{8'd30, 8'd60, 8'd90, 8'd200, 8'd20, 8'd20, 17'h17777}, 1'b0, '0},
    '{'{8'd85, 8'd170, 8'd255, 8'd255, 8'd170, 8'd85, 17'h0f000}, 1'b0, '0}
  };

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) begin
      send_pair(directed[i].p);
      if (directed[i].known && expected_colors[$] != directed[i].c) begin
        $display("%0t directed row %0d: typed %h, predicted %h", $time, i,
                 directed[i].c, expected_colors[$]);
        errors++;
      end
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_req = 1'b1;
      send_pair(rand_pair());
    end
    in_valid_i <= 1'b0;
    feed_done = 1'b1;
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    int cnt;
    wait (hold_req);
    hold_off = 1'b1;
    cnt = 0;
    while (cnt < 200) begin
      @(posedge clk_i);
      cnt++;
    end
    hold_off = 1'b0;
  end

  initial begin
    int n;
    wait (rst_ni);
    forever begin
      n = gap_len();
      if (n > 0) begin
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      n = $urandom_range(1, 21);
      repeat (n) begin
        out_ready_i <= !hold_off;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_colors.size() == 0) begin
        $display("%0t unexpected transfer %h %h %h", $time, out_red_o, out_green_o,
                 out_blue_o);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        if (out_red_o !== want.r) begin
          $display("%0t red expected %h actual %h", $time, want.r, out_red_o);
          errors++;
        end
        if (out_green_o !== want.g) begin
          $display("%0t green expected %h actual %h", $time, want.g, out_green_o);
          errors++;
        end
        if (out_blue_o !== want.b) begin
          $display("%0t blue expected %h actual %h", $time, want.b, out_blue_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("hsv_color_interpolator: mismatch");
      $finish;
    end
  end

  initial begin
    wait (feed_done);
    while (expected_colors.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);
    if (errors == 0) begin
      $display("hsv_color_interpolator: match");
    end else begin
      $display("hsv_color_interpolator: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/hci_pkg.sv
sv/hci_div.sv
sv/hsv_color_interpolator.sv
bench/tb.sv
